// ===== rtl/multi_voice_sample_mixer_core_macros.svh =====
// Assertion macros for the sample mixer core.
// Used by the back end; expects clk_i and rst_ni in scope.
`ifndef MULTI_VOICE_SAMPLE_MIXER_CORE_MACROS_SVH
`define MULTI_VOICE_SAMPLE_MIXER_CORE_MACROS_SVH

// Same-cycle implication.
`define MVSM_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("mixer assertion failed");

// Next-cycle implication.
`define MVSM_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mixer assertion failed");

`endif

// ===== rtl/mvsm_pkg.sv =====
// Shared types and codes for the sample mixer core.
// No dependencies.
`timescale 1ns / 1ps

package mvsm_pkg;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_STOP_ALL = 3'd3,
    OP_MIX      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_DRAIN,
    CS_DONE
  } ctl_state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [15:0] value;
    logic [16:0] length;
    logic [15:0] gain_l;
    logic [15:0] gain_r;
    logic [23:0] step;
    logic [15:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [15:0] base;
    logic [16:0] len;
    logic [32:0] pos;
    logic [23:0] step;
    logic [15:0] gain_l;
    logic [15:0] gain_r;
    logic [15:0] id;
  } voice_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] handle;
    logic [1:0]  status;
  } res_t;

endpackage

// ===== rtl/multi_voice_sample_mixer_core.sv =====
// Top level of the multi-voice sample mixer: config register and wiring.
// Depends on mvsm_pkg, mvsm_front, mvsm_fifo and mvsm_back.
//
// channel | direction | handshake            | word
// in      | input     | in_valid_i/in_stall_o | op, addr, value, length, amp, pan, step, handle
// out     | output    | out_valid_o/out_stall_i | left, right, handle, status, active voices
// cfg     | input     | cfg_valid_i/cfg_ready_o | stereo mode bit
//
// Load, start, stop-all and an empty table go straight to the result in the back end;
// stop by handle and mix scan the voice table once per active voice, and mix reads
// the one read port of the sample memory once per voice, then drains its pipeline.
// Reset clears control state only; sample memory is undefined until loaded.
// The front register and a two-word queue keep taking input while a result is held.
`timescale 1ns / 1ps

module multi_voice_sample_mixer_core #(
  parameter int MAX_VOICES       = 16,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [15:0]        sample_addr_i,
  input  logic signed [15:0] sample_value_i,
  input  logic [16:0]        voice_length_i,
  input  logic [15:0]        amplitude_i,
  input  logic signed [15:0] pan_i,
  input  logic [23:0]        step_rate_i,
  input  logic [15:0]        handle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic [15:0]        voice_handle_o,
  output logic [1:0]         status_o,
  output logic [$clog2(MAX_VOICES + 1)-1:0] active_voices_o
);

  localparam int CW = $clog2(MAX_VOICES + 1);

  logic           stereo_q;
  logic           push, full, pop, empty;
  mvsm_pkg::cmd_t fcmd, qcmd;
  mvsm_pkg::res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stereo_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      stereo_q <= cfg_data_i;
    end
  end

  mvsm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .sample_addr_i  (sample_addr_i),
    .sample_value_i (sample_value_i),
    .voice_length_i (voice_length_i),
    .amplitude_i    (amplitude_i),
    .pan_i          (pan_i),
    .step_rate_i    (step_rate_i),
    .handle_i       (handle_i),
    .stereo_i       (stereo_q),
    .push_o         (push),
    .cmd_o          (fcmd),
    .full_i         (full)
  );

  mvsm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (fcmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (qcmd),
    .empty_o (empty)
  );

  mvsm_back #(
    .MAX_VOICES       (MAX_VOICES),
    .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH),
    .CW               (CW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stereo_i    (stereo_q),
    .empty_i     (empty),
    .cmd_i       (qcmd),
    .pop_o       (pop),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res),
    .count_o     (active_voices_o)
  );

  assign left_out_o     = res.left;
  assign right_out_o    = res.right;
  assign voice_handle_o = res.handle;
  assign status_o       = res.status;

endmodule

// ===== rtl/mvsm_front.sv =====
// Input stage: registers one word, works out voice gains, pushes commands.
// Depends on mvsm_pkg.
`timescale 1ns / 1ps

module mvsm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [15:0]        sample_addr_i,
  input  logic [15:0]        sample_value_i,
  input  logic [16:0]        voice_length_i,
  input  logic [15:0]        amplitude_i,
  input  logic signed [15:0] pan_i,
  input  logic [23:0]        step_rate_i,
  input  logic [15:0]        handle_i,
  input  logic               stereo_i,
  output logic               push_o,
  output mvsm_pkg::cmd_t     cmd_o,
  input  logic               full_i
);

  logic               valid_q, valid_d;
  logic [2:0]         op_q;
  logic [15:0]        addr_q, value_q, amp_q, handle_q;
  logic [16:0]        len_q;
  logic signed [15:0] pan_q;
  logic [23:0]        step_q;
  logic               accept;
  logic signed [17:0] wl_s, wr_s;
  logic [32:0]        prod_l, prod_r;

  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      addr_q   <= sample_addr_i;
      value_q  <= sample_value_i;
      len_q    <= voice_length_i;
      amp_q    <= amplitude_i;
      pan_q    <= pan_i;
      step_q   <= step_rate_i;
      handle_q <= handle_i;
    end
  end

  assign wl_s   = 18'sd32768 - 18'(pan_q);
  assign wr_s   = 18'sd32768 + 18'(pan_q);
  assign prod_l = 33'(amp_q) * 33'(wl_s[16:0]);
  assign prod_r = 33'(amp_q) * 33'(wr_s[16:0]);

  always_comb begin
    cmd_o.op     = op_q;
    cmd_o.addr   = addr_q;
    cmd_o.value  = value_q;
    cmd_o.length = len_q;
    cmd_o.step   = step_q;
    cmd_o.handle = handle_q;
    if (stereo_i) begin
      cmd_o.gain_l = prod_l[31:16];
      cmd_o.gain_r = prod_r[31:16];
    end else begin
      cmd_o.gain_l = amp_q;
      cmd_o.gain_r = amp_q;
    end
  end

endmodule

// ===== rtl/mvsm_fifo.sv =====
// Two-entry command queue between front and back.
// Depends on mvsm_pkg.
`timescale 1ns / 1ps

module mvsm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mvsm_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output mvsm_pkg::cmd_t cmd_o,
  output logic           empty_o
);

  mvsm_pkg::cmd_t slot_q [2];
  logic           wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign cmd_o   = slot_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/mvsm_back.sv =====
// Back end: sample memory, voice table, mix pipeline and result register.
// Depends on mvsm_pkg and the core macro header.
`timescale 1ns / 1ps
`include "multi_voice_sample_mixer_core_macros.svh"

module mvsm_back #(
  parameter int MAX_VOICES       = 16,
  parameter int SAMPLE_MEM_DEPTH = 65536,
  parameter int CW               = $clog2(MAX_VOICES + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           stereo_i,
  input  logic           empty_i,
  input  mvsm_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           res_valid_o,
  input  logic           res_stall_i,
  output mvsm_pkg::res_t res_o,
  output logic [CW-1:0]  count_o
);

  localparam int IW   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int AW   = $clog2(SAMPLE_MEM_DEPTH);
  localparam int SW   = ((AW > 17) ? AW : 17) + 1;
  localparam int ACCW = 34 + IW;

  mvsm_pkg::ctl_state_e state_q, state_d;
  mvsm_pkg::cmd_t       cmd_q;
  mvsm_pkg::res_t       res_q;
  mvsm_pkg::voice_t     voice_tab_q [MAX_VOICES];
  mvsm_pkg::voice_t     cur, tab_wdata;
  logic [15:0]          sample_mem_q [SAMPLE_MEM_DEPTH];

  logic [CW-1:0]   count_q, k_q, w_q;
  logic [15:0]     next_handle_q;
  logic            found_q, s1_q, s2_q;
  logic [15:0]     gl1_q, gr1_q, rd_data_q;
  logic signed [32:0] pl_q, pr_q;
  logic signed [ACCW-1:0] accl_q, accr_q;

  logic            is_mix, last, drop, mix_drop, stop_drop, scan, start_ok;
  logic            tab_we, mem_we, mem_re, drained;
  logic [IW-1:0]   tab_widx;
  logic [33:0]     pos_sum;
  logic [SW-1:0]   rd_sum, ld_sum;
  logic [15:0]     sat_l, sat_r;

  function automatic logic [15:0] sat16(input logic signed [ACCW-1:0] acc);
    logic signed [ACCW-1:0] adj;
    logic signed [ACCW-1:0] q;
    adj = acc + (acc[ACCW-1] ? ACCW'(32767) : ACCW'(0));
    q   = adj >>> 15;
    if (q > ACCW'(32767)) begin
      sat16 = 16'h7fff;
    end else if (q < -ACCW'(32768)) begin
      sat16 = 16'h8000;
    end else begin
      sat16 = q[15:0];
    end
  endfunction

  assign scan      = state_q == mvsm_pkg::CS_SCAN;
  assign is_mix    = cmd_q.op == mvsm_pkg::OP_MIX;
  assign cur       = voice_tab_q[k_q[IW-1:0]];
  assign pos_sum   = 34'(cur.pos) + 34'(cur.step);
  assign mix_drop  = pos_sum >= {1'b0, cur.len, 16'b0};
  assign stop_drop = !found_q && (cur.id == cmd_q.handle);
  assign drop      = is_mix ? mix_drop : stop_drop;
  assign last      = k_q == count_q - CW'(1);
  assign start_ok  = count_q < CW'(MAX_VOICES);
  assign drained   = !s1_q && !s2_q;
  assign rd_sum    = SW'(cur.base) + SW'(cur.pos[32:16]);
  assign ld_sum    = SW'(cmd_i.addr);
  assign mem_we    = pop_o && (cmd_i.op == mvsm_pkg::OP_LOAD);
  assign mem_re    = scan && is_mix;
  assign sat_l     = sat16(accl_q);
  assign sat_r     = stereo_i ? sat16(accr_q) : 16'd0;

  always_comb begin
    tab_we    = 1'b0;
    tab_widx  = w_q[IW-1:0];
    tab_wdata = cur;
    if (scan) begin
      tab_we = !drop;
      if (is_mix) begin
        tab_wdata.pos = pos_sum[32:0];
      end
    end else if (pop_o && cmd_i.op == mvsm_pkg::OP_START && start_ok) begin
      tab_we           = 1'b1;
      tab_widx         = count_q[IW-1:0];
      tab_wdata.base   = cmd_i.addr;
      tab_wdata.len    = cmd_i.length;
      tab_wdata.pos    = '0;
      tab_wdata.step   = cmd_i.step;
      tab_wdata.gain_l = cmd_i.gain_l;
      tab_wdata.gain_r = cmd_i.gain_r;
      tab_wdata.id     = next_handle_q;
    end
  end

  always_comb begin
    pop_o       = (state_q == mvsm_pkg::CS_IDLE) && !empty_i;
    res_valid_o = state_q == mvsm_pkg::CS_DONE;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mvsm_pkg::CS_IDLE: begin
        if (pop_o) begin
          if ((cmd_i.op == mvsm_pkg::OP_MIX || cmd_i.op == mvsm_pkg::OP_STOP) &&
              count_q != '0) begin
            state_d = mvsm_pkg::CS_SCAN;
          end else begin
            state_d = mvsm_pkg::CS_DONE;
          end
        end
      end
      mvsm_pkg::CS_SCAN: begin
        if (last) begin
          state_d = is_mix ? mvsm_pkg::CS_DRAIN : mvsm_pkg::CS_DONE;
        end
      end
      mvsm_pkg::CS_DRAIN: begin
        if (drained) begin
          state_d = mvsm_pkg::CS_DONE;
        end
      end
      mvsm_pkg::CS_DONE: begin
        if (!res_stall_i) begin
          state_d = mvsm_pkg::CS_IDLE;
        end
      end
      default: state_d = mvsm_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mvsm_pkg::CS_IDLE;
      count_q       <= '0;
      next_handle_q <= '0;
      k_q           <= '0;
      w_q           <= '0;
      found_q       <= 1'b0;
      s1_q          <= 1'b0;
      s2_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      s1_q    <= mem_re;
      s2_q    <= s1_q;
      if (pop_o) begin
        k_q     <= '0;
        w_q     <= '0;
        found_q <= 1'b0;
        unique case (cmd_i.op)
          mvsm_pkg::OP_START: begin
            if (start_ok) begin
              count_q       <= count_q + CW'(1);
              next_handle_q <= next_handle_q + 16'd1;
            end
          end
          mvsm_pkg::OP_STOP_ALL: count_q <= '0;
          default: ;
        endcase
      end else if (scan) begin
        k_q <= k_q + CW'(1);
        if (!drop) begin
          w_q <= w_q + CW'(1);
        end else if (!is_mix) begin
          found_q <= 1'b1;
        end
        if (last) begin
          count_q <= drop ? w_q : w_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gl1_q <= cur.gain_l;
    gr1_q <= cur.gain_r;
    pl_q  <= $signed(rd_data_q) * $signed({1'b0, gl1_q});
    pr_q  <= $signed(rd_data_q) * $signed({1'b0, gr1_q});
    if (pop_o) begin
      cmd_q  <= cmd_i;
      res_q  <= '0;
      accl_q <= '0;
      accr_q <= '0;
      if (cmd_i.op == mvsm_pkg::OP_START) begin
        if (start_ok) begin
          res_q.handle <= next_handle_q;
        end else begin
          res_q.status <= mvsm_pkg::STAT_FULL;
        end
      end else if (cmd_i.op == mvsm_pkg::OP_STOP && count_q == '0) begin
        res_q.status <= mvsm_pkg::STAT_NOT_FOUND;
      end
    end else begin
      if (s2_q) begin
        accl_q <= accl_q + ACCW'(pl_q);
        accr_q <= accr_q + ACCW'(pr_q);
      end
      if (scan && last && !is_mix) begin
        res_q.status <= (found_q || stop_drop) ? mvsm_pkg::STAT_OK
                                               : mvsm_pkg::STAT_NOT_FOUND;
      end
      if (state_q == mvsm_pkg::CS_DRAIN && drained) begin
        res_q.left  <= sat_l;
        res_q.right <= sat_r;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      voice_tab_q[tab_widx] <= tab_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sample_mem_q[ld_sum[AW-1:0]] <= cmd_i.value;
    end
    if (mem_re) begin
      rd_data_q <= sample_mem_q[rd_sum[AW-1:0]];
    end
  end

  assign res_o   = res_q;
  assign count_o = count_q;

  `MVSM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_VOICES))
  `MVSM_ASSERT_NOW(a_compact_order, scan, w_q <= k_q && k_q < count_q)
  `MVSM_ASSERT_NEXT(a_pipe_flow, s1_q, s2_q)
  `MVSM_ASSERT_NOW(a_drain_mix_only, state_q == mvsm_pkg::CS_DRAIN, is_mix)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for multi_voice_sample_mixer_core: directed and random tests.
// Depends on mvsm_pkg and the mixer RTL; an inline voice-table predictor supplies expected words.
`timescale 1ns / 1ps

module tb;

  localparam int NV = 16;
  localparam int WD_LIMIT = 5000;
  localparam int SETTLE = 40;
  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;
  localparam logic CFG_MONO = 1'b0;
  localparam logic CFG_STEREO = 1'b1;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [15:0] value;
    logic [16:0] length;
    logic [15:0] amp;
    logic [15:0] pan;
    logic [23:0] step;
    logic [15:0] handle;
  } cmd_word_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] handle;
    logic [1:0]  status;
    logic [4:0]  active;
  } mix_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] op_i = '0;
  logic [15:0] sample_addr_i = '0;
  logic signed [15:0] sample_value_i = '0;
  logic [16:0] voice_length_i = '0;
  logic [15:0] amplitude_i = '0;
  logic signed [15:0] pan_i = '0;
  logic [23:0] step_rate_i = '0;
  logic [15:0] handle_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] left_out_o;
  logic signed [15:0] right_out_o;
  logic [15:0] voice_handle_o;
  logic [1:0] status_o;
  logic [4:0] active_voices_o;

  always #1 clk_i = ~clk_i;

  multi_voice_sample_mixer_core i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .op_i, .sample_addr_i, .sample_value_i,
    .voice_length_i, .amplitude_i, .pan_i, .step_rate_i, .handle_i,
    .out_valid_o, .out_stall_i, .left_out_o, .right_out_o,
    .voice_handle_o, .status_o, .active_voices_o
  );

  logic signed [15:0] mem_q [65536];
  bit mem_written [65536];
  logic [15:0] v_base [NV];
  logic [16:0] v_len [NV];
  longint unsigned v_pos [NV];
  logic [23:0] v_step [NV];
  logic [15:0] v_gl [NV];
  logic [15:0] v_gr [NV];
  logic [15:0] v_id [NV];
  int v_count = 0;
  logic [15:0] next_handle = '0;
  logic stereo = 1'b1;

  mix_word_t expected_q [$];
  int fail_count = 0;
  int idle_cycles = 0;
  int sent_count = 0;
  bit no_gaps = 1'b0;

  function automatic logic [15:0] sat_q15(longint acc);
    longint v;
    v = acc / 32768;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic void drop_voice(int k);
    for (int l = k + 1; l < v_count; l++) begin
      v_base[l-1] = v_base[l];
      v_len[l-1] = v_len[l];
      v_pos[l-1] = v_pos[l];
      v_step[l-1] = v_step[l];
      v_gl[l-1] = v_gl[l];
      v_gr[l-1] = v_gr[l];
      v_id[l-1] = v_id[l];
    end
    v_count--;
  endfunction

  function automatic mix_word_t mixer_predict(cmd_word_t w);
    mix_word_t r;
    longint acc_l, acc_r, p, amp;
    logic [15:0] a;
    int k;
    r = '{default: '0};
    acc_l = 0;
    acc_r = 0;
    case (w.op)
      mvsm_pkg::OP_LOAD: begin
        mem_q[w.addr] = w.value;
        mem_written[w.addr] = 1'b1;
      end
      mvsm_pkg::OP_START: begin
        if (v_count >= NV) begin
          r.status = mvsm_pkg::STAT_FULL;
        end else begin
          amp = longint'(w.amp);
          p = longint'($signed(w.pan));
          if (stereo) begin
            v_gl[v_count] = 16'((amp * (32768 - p)) >> 16);
            v_gr[v_count] = 16'((amp * (32768 + p)) >> 16);
          end else begin
            v_gl[v_count] = w.amp;
            v_gr[v_count] = w.amp;
          end
          v_base[v_count] = w.addr;
          v_len[v_count] = w.length;
          v_step[v_count] = w.step;
          v_pos[v_count] = 0;
          v_id[v_count] = next_handle;
          r.handle = next_handle;
          next_handle++;
          v_count++;
        end
      end
      mvsm_pkg::OP_STOP: begin
        r.status = mvsm_pkg::STAT_NOT_FOUND;
        for (k = 0; k < v_count; k++) begin
          if (v_id[k] == w.handle) begin
            drop_voice(k);
            r.status = mvsm_pkg::STAT_OK;
            break;
          end
        end
      end
      mvsm_pkg::OP_STOP_ALL: v_count = 0;
      mvsm_pkg::OP_MIX: begin
        k = 0;
        while (k < v_count) begin
          a = v_base[k] + 16'(v_pos[k] >> 16);
          acc_l += longint'(mem_q[a]) * longint'(v_gl[k]);
          acc_r += longint'(mem_q[a]) * longint'(v_gr[k]);
          v_pos[k] += v_step[k];
          if (v_pos[k] >= (longint'(v_len[k]) << 16)) drop_voice(k);
          else k++;
        end
        r.left = sat_q15(acc_l);
        r.right = stereo ? sat_q15(acc_r) : '0;
      end
      default: ;
    endcase
    r.active = 5'(v_count);
    return r;
  endfunction

  function automatic cmd_word_t rand_word(logic [2:0] op);
    cmd_word_t w;
    w.op = op;
    w.addr = 16'($urandom);
    w.value = 16'($urandom);
    w.length = 17'($urandom);
    w.amp = 16'($urandom_range(32768));
    w.pan = 16'($urandom);
    w.step = 24'($urandom);
    w.handle = 16'($urandom);
    return w;
  endfunction

  task automatic send_word(cmd_word_t w);
    if (!no_gaps) begin
      while ($urandom_range(99) < 23) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    op_i <= w.op;
    sample_addr_i <= w.addr;
    sample_value_i <= w.value;
    voice_length_i <= w.length;
    amplitude_i <= w.amp;
    pan_i <= w.pan;
    step_rate_i <= w.step;
    handle_i <= w.handle;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(mixer_predict(w));
    sent_count++;
  endtask

  task automatic load_word(logic [15:0] addr, logic [15:0] value);
    cmd_word_t w;
    w = rand_word(mvsm_pkg::OP_LOAD);
    w.addr = addr;
    w.value = value;
    send_word(w);
  endtask

  task automatic start_voice(logic [15:0] base, logic [16:0] len, logic [15:0] amp,
                             logic [15:0] pan, logic [23:0] step);
    cmd_word_t w;
    w = rand_word(mvsm_pkg::OP_START);
    w.addr = base;
    w.length = len;
    w.amp = amp;
    w.pan = pan;
    w.step = step;
    send_word(w);
  endtask

  task automatic stop_voice(logic [15:0] h);
    cmd_word_t w;
    w = rand_word(mvsm_pkg::OP_STOP);
    w.handle = h;
    send_word(w);
  endtask

  // load any word the next frame will read that is still unwritten
  task automatic mix_frame();
    logic [15:0] a;
    for (int k = 0; k < v_count; k++) begin
      a = v_base[k] + 16'(v_pos[k] >> 16);
      if (!mem_written[a]) load_word(a, 16'($urandom));
    end
    send_word(rand_word(mvsm_pkg::OP_MIX));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_mode(logic mode);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    stereo = mode;
  endtask

  task automatic test_directed();
    load_word(16'h0000, 16'h7FFF);
    load_word(16'hFFFF, 16'h8000);
    load_word(16'h0100, 16'h7FFF);
    for (int i = 0; i < 4; i++) start_voice(16'h0100, 17'd1, 16'd32768, 16'h8000, 24'd0);
    mix_frame();
    start_voice(16'hFFFF, 17'd0, 16'd32768, 16'h7FFF, 24'd0);
    start_voice(16'hFFFF, 17'd65536 - 1, 16'd0, 16'h0000, 24'hFFFFFF);
    start_voice(16'h0000, 17'h1FFFF, 16'hFFFF, 16'h7FFF, 24'h010000);
    for (int i = 0; i < 11; i++) start_voice(16'hFFFF, 17'd3, 16'd32768, 16'h8000, 24'h00C000);
    mix_frame();
    mix_frame();
    stop_voice(v_id[1]);
    stop_voice(next_handle + 16'd100);
    send_word(rand_word(OP_RSVD_A));
    send_word(rand_word(OP_RSVD_B));
    send_word(rand_word(OP_RSVD_C));
    send_word(rand_word(mvsm_pkg::OP_STOP_ALL));
    mix_frame();
  endtask

  task automatic test_random(int n);
    cmd_word_t w;
    int sel;
    int first;
    first = sent_count;
    while (sent_count < first + n) begin
      no_gaps = (sent_count - first >= n / 3) && (sent_count - first < n / 3 + 150);
      sel = $urandom_range(99);
      if (sel < 15) begin
        send_word(rand_word(mvsm_pkg::OP_LOAD));
      end else if (sel < 40) begin
        w = rand_word(mvsm_pkg::OP_START);
        if ($urandom_range(9) != 0) begin
          w.length = 17'($urandom_range(1, 40));
          w.step = 24'($urandom_range(0, 24'h30000));
        end
        send_word(w);
      end else if (sel < 52) begin
        w = rand_word(mvsm_pkg::OP_STOP);
        if (v_count != 0 && $urandom_range(3) != 0) w.handle = v_id[$urandom_range(v_count - 1)];
        send_word(w);
      end else if (sel < 54) begin
        send_word(rand_word(mvsm_pkg::OP_STOP_ALL));
      end else if (sel < 56) begin
        send_word(rand_word(3'($urandom_range(OP_RSVD_A, OP_RSVD_C))));
      end else begin
        mix_frame();
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_wait_idle();
    drain();
    repeat (5) mix_frame();
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !no_gaps && ($urandom_range(99) < 23);
  end

  always @(posedge clk_i) begin
    mix_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected output word");
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (left_out_o !== e.left) begin
          $error("left_out expected %0d got %0d", $signed(e.left), left_out_o);
          fail_count++;
        end
        if (right_out_o !== e.right) begin
          $error("right_out expected %0d got %0d", $signed(e.right), right_out_o);
          fail_count++;
        end
        if (voice_handle_o !== e.handle) begin
          $error("voice_handle expected %0d got %0d", e.handle, voice_handle_o);
          fail_count++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d got %0d", e.status, status_o);
          fail_count++;
        end
        if (active_voices_o !== e.active) begin
          $error("active_voices expected %0d got %0d", e.active, active_voices_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    write_mode(CFG_STEREO);
    test_directed();
    write_mode(CFG_MONO);
    test_directed();
    test_random(300);
    write_mode(CFG_STEREO);
    test_random(900);
    test_wait_idle();
    write_mode(CFG_MONO);
    test_random(250);
    write_mode(CFG_STEREO);
    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
